@@ rtl/core/bsfr_pkg.sv @@
`timescale 1ns / 1ps

package bsfr_pkg;

    // Largest frame length that is counted; longer frames saturate here.
    localparam int unsigned MAX_FRAME = 4096;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned COUNT_HW_MAX = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_FRAME > COUNT_HW_MAX) ? COUNT_W'(COUNT_HW_MAX) : COUNT_W'(MAX_FRAME);
    localparam logic [COUNT_W-1:0] MIN_OK_LEN = COUNT_W'(4);

    // Line framing bytes and escape codes.
    localparam logic [7:0] BYTE_START = 8'hAA;
    localparam logic [7:0] BYTE_END   = 8'hCC;
    localparam logic [7:0] BYTE_ESC   = 8'hBB;
    localparam logic [7:0] CODE_START = 8'h55;
    localparam logic [7:0] CODE_ESC   = 8'h44;
    localparam logic [7:0] CODE_END   = 8'h33;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_DATA        = 3'd0,
        KIND_OK          = 3'd1,
        KIND_BADSUM      = 3'd2,
        KIND_SHORT       = 3'd3,
        KIND_FALSE_START = 3'd4,
        KIND_BAD_ESC     = 3'd5,
        KIND_STRAY       = 3'd6
    } kind_t;

    // Width of the packed result data bus in bits.
    localparam int unsigned OUT_DATA_W = 48;

endpackage

@@ rtl/core/byte_stuffed_frame_receiver.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Ports                      Contents
// s_        in         s_tvalid s_tready s_tdata  one raw line byte
// m_        out        m_tvalid m_tready m_tdata  result fields, m_tuser holds kind
//
// Each byte is decoded from the input register once the output register can take
// a result, and any result that its decode yields is loaded into the output
// register; one byte per cycle while the output is not stalled.
// The output register is loaded only when it is empty or being emptied, and the
// input register can still take a byte while a result waits, if it is empty.
// aresetn is synchronous and active low; it clears all frame state.
module byte_stuffed_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [bsfr_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tdata: [7:0] data_byte, [20:8] frame_length, [28:21] header_flags,
    //          [44:29] payload_id, [47:45] zero
    output logic [2:0]  m_tuser    // [2:0] kind
);

    localparam int unsigned CW = bsfr_pkg::COUNT_W;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Frame state.
    logic          in_frame_reg, in_frame_next;
    logic          in_escape_reg, in_escape_next;
    logic          held_valid_reg, held_valid_next;
    logic [7:0]    held_byte_reg, held_byte_next;
    logic [7:0]    running_sum_reg, running_sum_next;
    logic [CW-1:0] content_count_reg, content_count_next;
    logic [7:0]    flags_byte_reg, flags_byte_next;
    logic [15:0]   id_word_reg, id_word_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    bsfr_pkg::kind_t       kind_reg, kind_next;
    logic [7:0]            data_byte_reg, data_byte_next;
    logic [CW-1:0]         frame_length_reg, frame_length_next;
    logic [7:0]            header_flags_reg, header_flags_next;
    logic [15:0]           payload_id_reg, payload_id_next;

    logic       proc_ready;
    logic       proc_fire;
    logic       res_valid;
    logic       content_take;
    logic [7:0] content_byte;

    assign proc_ready = !m_valid_reg || m_tready;
    assign proc_fire  = in_valid_reg && proc_ready;
    assign s_tready   = !in_valid_reg || proc_ready;

    // Input register handshake.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (proc_fire) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    // Decode of one line byte: frame state update and result.
    always_comb begin
        in_frame_next      = in_frame_reg;
        in_escape_next     = in_escape_reg;
        held_valid_next    = held_valid_reg;
        held_byte_next     = held_byte_reg;
        running_sum_next   = running_sum_reg;
        content_count_next = content_count_reg;
        flags_byte_next    = flags_byte_reg;
        id_word_next       = id_word_reg;
        res_valid          = 1'b0;
        kind_next          = bsfr_pkg::KIND_DATA;
        data_byte_next     = '0;
        frame_length_next  = '0;
        header_flags_next  = '0;
        payload_id_next    = '0;
        content_take       = 1'b0;
        content_byte       = in_byte_reg;

        if (proc_fire) begin
            priority if (in_byte_reg == bsfr_pkg::BYTE_START) begin
                if (in_frame_reg) begin
                    res_valid = 1'b1;
                    kind_next = bsfr_pkg::KIND_FALSE_START;
                end
                in_frame_next = 1'b1;
            end else if (!in_frame_reg) begin
                res_valid      = 1'b1;
                kind_next      = bsfr_pkg::KIND_STRAY;
                data_byte_next = in_byte_reg;
            end else if (in_byte_reg == bsfr_pkg::BYTE_END) begin
                res_valid         = 1'b1;
                frame_length_next = content_count_reg;
                priority if (content_count_reg == '0 || !held_valid_reg) begin
                    kind_next = bsfr_pkg::KIND_SHORT;
                end else if (running_sum_reg != held_byte_reg) begin
                    kind_next = bsfr_pkg::KIND_BADSUM;
                end else if (content_count_reg < bsfr_pkg::MIN_OK_LEN) begin
                    kind_next = bsfr_pkg::KIND_SHORT;
                end else begin
                    kind_next         = bsfr_pkg::KIND_OK;
                    header_flags_next = flags_byte_reg;
                    payload_id_next   = id_word_reg;
                end
                in_frame_next = 1'b0;
            end else if (in_escape_reg) begin
                in_escape_next = 1'b0;
                priority if (in_byte_reg == bsfr_pkg::CODE_START) begin
                    content_take = 1'b1;
                    content_byte = bsfr_pkg::BYTE_START;
                end else if (in_byte_reg == bsfr_pkg::CODE_ESC) begin
                    content_take = 1'b1;
                    content_byte = bsfr_pkg::BYTE_ESC;
                end else if (in_byte_reg == bsfr_pkg::CODE_END) begin
                    content_take = 1'b1;
                    content_byte = bsfr_pkg::BYTE_END;
                end else begin
                    res_valid      = 1'b1;
                    kind_next      = bsfr_pkg::KIND_BAD_ESC;
                    data_byte_next = in_byte_reg;
                end
            end else if (in_byte_reg == bsfr_pkg::BYTE_ESC) begin
                in_escape_next = 1'b1;
            end else begin
                content_take = 1'b1;
            end

            // Start and end bytes clear the frame, including the escape flag.
            if (in_byte_reg == bsfr_pkg::BYTE_START
                    || (in_frame_reg && in_byte_reg == bsfr_pkg::BYTE_END)) begin
                in_escape_next     = 1'b0;
                held_valid_next    = 1'b0;
                held_byte_next     = '0;
                running_sum_next   = '0;
                content_count_next = '0;
                flags_byte_next    = '0;
                id_word_next       = '0;
            end

            // Content byte: capture header fields, pass out the held byte.
            if (content_take) begin
                if (content_count_reg == CW'(0)) begin
                    flags_byte_next = content_byte;
                end else if (content_count_reg == CW'(1)) begin
                    id_word_next = {content_byte, id_word_reg[7:0]};
                end else if (content_count_reg == CW'(2)) begin
                    id_word_next = {id_word_reg[15:8], content_byte};
                end
                if (content_count_reg < bsfr_pkg::COUNT_CAP) begin
                    content_count_next = content_count_reg + CW'(1);
                end
                if (held_valid_reg) begin
                    running_sum_next = running_sum_reg + held_byte_reg;
                    res_valid        = 1'b1;
                    kind_next        = bsfr_pkg::KIND_DATA;
                    data_byte_next   = held_byte_reg;
                end
                held_byte_next  = content_byte;
                held_valid_next = 1'b1;
            end
        end
    end

    // Output register handshake.
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            in_frame_reg      <= 1'b0;
            in_escape_reg     <= 1'b0;
            held_valid_reg    <= 1'b0;
            held_byte_reg     <= '0;
            running_sum_reg   <= '0;
            content_count_reg <= '0;
            flags_byte_reg    <= '0;
            id_word_reg       <= '0;
        end else begin
            in_valid_reg      <= in_valid_next;
            m_valid_reg       <= m_valid_next;
            in_frame_reg      <= in_frame_next;
            in_escape_reg     <= in_escape_next;
            held_valid_reg    <= held_valid_next;
            held_byte_reg     <= held_byte_next;
            running_sum_reg   <= running_sum_next;
            content_count_reg <= content_count_next;
            flags_byte_reg    <= flags_byte_next;
            id_word_reg       <= id_word_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (res_valid) begin
            kind_reg         <= kind_next;
            data_byte_reg    <= data_byte_next;
            frame_length_reg <= frame_length_next;
            header_flags_reg <= header_flags_next;
            payload_id_reg   <= payload_id_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {3'b000, payload_id_reg, header_flags_reg,
                       frame_length_reg, data_byte_reg};

endmodule
